// ===== rtl/core/rgbsls_pkg.sv =====
package rgbsls_pkg;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_PULSE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Colour codes as stored per LED
    typedef enum logic [2:0] {
        COLOR_OFF    = 3'd0,
        COLOR_RED    = 3'd1,
        COLOR_YELLOW = 3'd2,
        COLOR_GREEN  = 3'd3,
        COLOR_BLUE   = 3'd4
    } color_t;

    // Configuration register indexes
    localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [2:0] REG_BLINK_HALF = 3'd1;
    localparam logic [2:0] REG_PULSE_LEN  = 3'd2;
    localparam logic [2:0] REG_PULSE_GAP  = 3'd3;

    // Register reset values
    localparam logic [6:0]  BRIGHT_RESET     = 7'd100;
    localparam logic [15:0] BLINK_HALF_RESET = 16'd500;
    localparam logic [15:0] PULSE_LEN_RESET  = 16'd50;
    localparam logic [15:0] PULSE_GAP_RESET  = 16'd200;

    // Brightness clamp range and the extra colour factors, in percent
    localparam logic [6:0] BRIGHT_MIN  = 7'd5;
    localparam logic [6:0] PCT_FULL    = 7'd100;
    localparam logic [6:0] PCT_RED     = 7'd80;
    localparam logic [6:0] PCT_YELLOW  = 7'd60;

    // LEDs with pulse behaviour
    localparam logic [1:0] LED_GPS   = 2'd1;
    localparam logic [1:0] LED_STEER = 2'd2;

    // Saturation limit of all millisecond counters
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Divide by 100: multiply by floor(2^30 / 100), then one correction step
    localparam int          RECIP_W     = 24;
    localparam int          RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100   = 24'd10737418;

    // Micro-operations of the sequencer
    typedef enum logic [3:0] {
        UOP_WAIT,
        UOP_MUL,
        UOP_DIVM,
        UOP_DIVC,
        UOP_TICK,
        UOP_BLINK,
        UOP_PULSE,
        UOP_SET,
        UOP_PREQ,
        UOP_FLUSH
    } uop_t;

    // Step sequencing
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_NO_TOGGLE,
        COND_SCAN,
        COND_DISPATCH
    } cond_t;

    // Multiplier operand selects
    typedef enum logic [1:0] {
        OPA_FULL,
        OPA_HALF,
        OPA_FULL_S,
        OPA_HALF_S
    } opa_t;

    typedef enum logic [1:0] {
        OPB_BRIGHT,
        OPB_RED,
        OPB_YELLOW
    } opb_t;

    // Destination of a finished quotient
    typedef enum logic [2:0] {
        DST_NONE,
        DST_FULL,
        DST_HALF,
        DST_RED_R,
        DST_YEL_R,
        DST_YEL_G
    } dst_t;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    // Program entry points
    localparam pc_t PC_IDLE   = 5'd0;
    localparam pc_t PC_CAL    = 5'd1;
    localparam pc_t PC_TICK   = 5'd16;
    localparam pc_t PC_BLINK  = 5'd17;
    localparam pc_t PC_PULSE  = 5'd18;
    localparam pc_t PC_FINISH = 5'd19;
    localparam pc_t PC_SET    = 5'd20;
    localparam pc_t PC_PREQ   = 5'd21;

    typedef struct packed {
        uop_t  op;
        opa_t  opa;
        opb_t  opb;
        dst_t  dst;
        logic  cal_done;
        cond_t cond;
        pc_t   target;
    } uword_t;

    function automatic uword_t mk_uword(input uop_t op, input opa_t opa, input opb_t opb,
                                        input dst_t dst, input logic cal_done,
                                        input cond_t cond, input pc_t target);
        uword_t w;
        w.op       = op;
        w.opa      = opa;
        w.opb      = opb;
        w.dst      = dst;
        w.cal_done = cal_done;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    // Control store. The calibration routine derives the five scaled duty
    // values from brightness: multiply, reciprocal multiply, correct.
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        w = mk_uword(UOP_WAIT, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0, COND_DISPATCH, PC_IDLE);
        case (pc)
            PC_IDLE:         w = mk_uword(UOP_WAIT, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_DISPATCH, PC_IDLE);
            PC_CAL:          w = mk_uword(UOP_MUL, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd1:   w = mk_uword(UOP_DIVM, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd2:   w = mk_uword(UOP_DIVC, OPA_FULL, OPB_BRIGHT, DST_FULL, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd3:   w = mk_uword(UOP_MUL, OPA_HALF, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd4:   w = mk_uword(UOP_DIVM, OPA_HALF, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd5:   w = mk_uword(UOP_DIVC, OPA_HALF, OPB_BRIGHT, DST_HALF, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd6:   w = mk_uword(UOP_MUL, OPA_FULL_S, OPB_RED, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd7:   w = mk_uword(UOP_DIVM, OPA_FULL_S, OPB_RED, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd8:   w = mk_uword(UOP_DIVC, OPA_FULL_S, OPB_RED, DST_RED_R, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd9:   w = mk_uword(UOP_MUL, OPA_FULL_S, OPB_YELLOW, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd10:  w = mk_uword(UOP_DIVM, OPA_FULL_S, OPB_YELLOW, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd11:  w = mk_uword(UOP_DIVC, OPA_FULL_S, OPB_YELLOW, DST_YEL_R, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd12:  w = mk_uword(UOP_MUL, OPA_HALF_S, OPB_YELLOW, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd13:  w = mk_uword(UOP_DIVM, OPA_HALF_S, OPB_YELLOW, DST_NONE, 1'b0,
                                          COND_NEXT, PC_IDLE);
            PC_CAL + 5'd14:  w = mk_uword(UOP_DIVC, OPA_HALF_S, OPB_YELLOW, DST_YEL_G, 1'b1,
                                          COND_JUMP, PC_IDLE);
            PC_TICK:         w = mk_uword(UOP_TICK, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_NO_TOGGLE, PC_PULSE);
            PC_BLINK:        w = mk_uword(UOP_BLINK, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_SCAN, PC_PULSE);
            PC_PULSE:        w = mk_uword(UOP_PULSE, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_SCAN, PC_FINISH);
            PC_FINISH:       w = mk_uword(UOP_FLUSH, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_JUMP, PC_IDLE);
            PC_SET:          w = mk_uword(UOP_SET, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_JUMP, PC_FINISH);
            PC_PREQ:         w = mk_uword(UOP_PREQ, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_JUMP, PC_FINISH);
            default:         w = mk_uword(UOP_WAIT, OPA_FULL, OPB_BRIGHT, DST_NONE, 1'b0,
                                          COND_JUMP, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/rgb_status_led_sequencer.sv =====
// RGB status LED sequencer. Takes millisecond ticks, set-LED commands and blue
// pulse requests, and answers each with the new 12-bit duty triple of every LED
// whose drive changed, last_update marking the final beat of an item. A small
// microcoded sequencer walks the LEDs one per cycle while the result side does
// not stall it. Results pass through a one-beat holding register and an output
// register, so one beat waiting at the output does not stop the scan. Duty values
// are computed once, not per result: after reset and after every brightness write
// the sequencer works out the scaled levels with its shared multiplier, and
// s_ready stays low until that is done. Configuration writes are always taken;
// brightness clamps to 5..100 percent.
module rgb_status_led_sequencer #(
    parameter int LED_COUNT = 4,
    parameter int DUTY_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [1:0]           s_led_index,
    input  logic [2:0]           s_color_code,
    input  logic                 s_blink_mode,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_led_number,
    output logic [DUTY_BITS-1:0] m_red_duty,
    output logic [DUTY_BITS-1:0] m_green_duty,
    output logic [DUTY_BITS-1:0] m_blue_duty,
    output logic                 m_last_update,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int ACC_W  = DUTY_BITS + 7;
    localparam int PROD_W = ACC_W + rgbsls_pkg::RECIP_W;
    localparam logic [LED_W-1:0]     LAST_LED = LED_W'(LED_COUNT - 1);
    localparam logic [DUTY_BITS-1:0] FULL_VAL = {DUTY_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0] HALF_VAL = {1'b1, {(DUTY_BITS-1){1'b0}}};

    // Sequencer state
    rgbsls_pkg::pc_t     pc_reg, pc_next;
    rgbsls_pkg::uword_t  uw;
    logic [LED_W-1:0]    idx_reg, idx_next;
    logic                calib_pending_reg, calib_pending_next;
    logic [1:0]          cmd_led_reg;
    logic [2:0]          cmd_color_reg;
    logic                cmd_mode_reg;
    logic                latch_cmd;

    // Configuration
    logic [6:0]          bright_reg;
    logic [15:0]         half_period_reg;
    logic [15:0]         pulse_len_reg;
    logic [15:0]         min_gap_reg;
    logic [6:0]          bright_clamped;
    logic                bright_write;

    // Per-LED state
    rgbsls_pkg::color_t  color_reg [LED_COUNT];
    logic                blinks_reg [LED_COUNT];
    logic                phase_reg [LED_COUNT];
    logic                pulse_on_reg [LED_COUNT];
    logic [15:0]         age_reg [LED_COUNT];

    // Shared state
    logic                shared_phase_reg, shared_phase_next;
    logic [15:0]         blink_cnt_reg, blink_cnt_next;
    logic [15:0]         gap_cnt_reg, gap_cnt_next;

    // Arithmetic datapath
    logic [ACC_W-1:0]     acc_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [DUTY_BITS-1:0] full_s_reg, half_s_reg, red_r_reg, yel_r_reg, yel_g_reg;
    logic [DUTY_BITS-1:0] mul_a;
    logic [6:0]           mul_b;
    logic [ACC_W-1:0]     q_est, q_rem, q_fix;
    logic [DUTY_BITS-1:0] quot;

    // Per-LED write strobes for the addressed entry
    logic                color_we, blinks_we, phase_we, pulse_we, age_we;
    rgbsls_pkg::color_t  color_val;
    logic                blinks_val, phase_val, pulse_val;
    logic [15:0]         age_val;

    // Current entry
    rgbsls_pkg::color_t  cur_color;
    logic                cur_blinks, cur_phase, cur_pulse;
    logic [15:0]         cur_age, age_inc, blink_inc;
    logic                toggled;
    logic                go_pulse;

    // Drive computation inputs and outputs
    logic                drv_pulse, drv_lit;
    rgbsls_pkg::color_t  drv_color;
    logic [DUTY_BITS-1:0] drv_r, drv_g, drv_b;

    // Result staging
    logic                emit_req, flush_req, out_free, stall;
    logic                hold_valid_reg, hold_valid_next;
    logic [1:0]          hold_led_reg;
    logic [DUTY_BITS-1:0] hold_r_reg, hold_g_reg, hold_b_reg;
    logic                m_valid_reg, m_valid_next;
    logic                m_load;
    logic [1:0]          m_led_reg;
    logic [DUTY_BITS-1:0] m_r_reg, m_g_reg, m_b_reg;
    logic                m_last_reg;

    assign uw        = rgbsls_pkg::ucode_rom(pc_reg);
    assign s_ready   = (pc_reg == rgbsls_pkg::PC_IDLE) && !calib_pending_reg;
    assign cfg_ready = 1'b1;

    assign cur_color  = color_reg[idx_reg];
    assign cur_blinks = blinks_reg[idx_reg];
    assign cur_phase  = phase_reg[idx_reg];
    assign cur_pulse  = pulse_on_reg[idx_reg];
    assign cur_age    = age_reg[idx_reg];
    assign age_inc    = (cur_age == rgbsls_pkg::CNT_MAX) ? cur_age : cur_age + 16'd1;
    assign blink_inc  = (blink_cnt_reg == rgbsls_pkg::CNT_MAX) ? blink_cnt_reg
                                                               : blink_cnt_reg + 16'd1;
    assign toggled    = (blink_inc >= half_period_reg);

    // Brightness write clamps into 5..100
    assign bright_write = cfg_valid && (cfg_index == rgbsls_pkg::REG_BRIGHTNESS);
    always_comb begin
        bright_clamped = cfg_data[6:0];
        if (bright_clamped < rgbsls_pkg::BRIGHT_MIN) begin
            bright_clamped = rgbsls_pkg::BRIGHT_MIN;
        end else if (bright_clamped > rgbsls_pkg::PCT_FULL) begin
            bright_clamped = rgbsls_pkg::PCT_FULL;
        end
    end

    // Multiplier operands
    always_comb begin
        case (uw.opa)
            rgbsls_pkg::OPA_FULL:   mul_a = FULL_VAL;
            rgbsls_pkg::OPA_HALF:   mul_a = HALF_VAL;
            rgbsls_pkg::OPA_FULL_S: mul_a = full_s_reg;
            rgbsls_pkg::OPA_HALF_S: mul_a = half_s_reg;
            default:                mul_a = FULL_VAL;
        endcase
        case (uw.opb)
            rgbsls_pkg::OPB_BRIGHT: mul_b = bright_reg;
            rgbsls_pkg::OPB_RED:    mul_b = rgbsls_pkg::PCT_RED;
            rgbsls_pkg::OPB_YELLOW: mul_b = rgbsls_pkg::PCT_YELLOW;
            default:                mul_b = rgbsls_pkg::PCT_FULL;
        endcase
    end

    // Divide-by-100 correction: estimate is the true quotient or one short
    assign q_est = ACC_W'(prod_reg[PROD_W-1:rgbsls_pkg::RECIP_SHIFT]);
    assign q_rem = acc_reg - (q_est * ACC_W'(rgbsls_pkg::PCT_FULL));
    assign q_fix = (q_rem >= ACC_W'(rgbsls_pkg::PCT_FULL)) ? q_est + ACC_W'(1) : q_est;
    assign quot  = DUTY_BITS'(q_fix);

    // Duty triple for one LED from the precomputed levels
    always_comb begin
        drv_r = '0;
        drv_g = '0;
        drv_b = '0;
        if (drv_pulse) begin
            drv_b = full_s_reg;
        end else if (drv_lit) begin
            case (drv_color)
                rgbsls_pkg::COLOR_RED: begin
                    drv_r = red_r_reg;
                end
                rgbsls_pkg::COLOR_YELLOW: begin
                    drv_r = yel_r_reg;
                    drv_g = yel_g_reg;
                end
                rgbsls_pkg::COLOR_GREEN: begin
                    drv_g = full_s_reg;
                end
                rgbsls_pkg::COLOR_BLUE: begin
                    drv_b = full_s_reg;
                end
                default: begin
                    drv_r = '0;
                end
            endcase
        end
    end

    // Micro-operation decode
    always_comb begin
        emit_req   = 1'b0;
        flush_req  = 1'b0;
        color_we   = 1'b0;
        blinks_we  = 1'b0;
        phase_we   = 1'b0;
        pulse_we   = 1'b0;
        age_we     = 1'b0;
        color_val  = rgbsls_pkg::COLOR_OFF;
        blinks_val = 1'b0;
        phase_val  = 1'b0;
        pulse_val  = 1'b0;
        age_val    = age_inc;
        drv_pulse  = cur_pulse;
        drv_color  = cur_color;
        drv_lit    = !cur_blinks || cur_phase;
        go_pulse   = 1'b0;
        case (uw.op)
            rgbsls_pkg::UOP_BLINK: begin
                emit_req  = cur_blinks;
                phase_we  = cur_blinks;
                phase_val = shared_phase_reg;
                drv_lit   = shared_phase_reg;
            end
            rgbsls_pkg::UOP_PULSE: begin
                age_we    = cur_pulse;
                pulse_we  = cur_pulse && (age_inc >= pulse_len_reg);
                pulse_val = 1'b0;
                emit_req  = pulse_we;
                drv_pulse = 1'b0;
            end
            rgbsls_pkg::UOP_SET: begin
                color_we   = 1'b1;
                blinks_we  = 1'b1;
                phase_we   = 1'b1;
                color_val  = (cmd_color_reg > 3'(rgbsls_pkg::COLOR_BLUE))
                             ? rgbsls_pkg::COLOR_OFF : rgbsls_pkg::color_t'(cmd_color_reg);
                blinks_val = cmd_mode_reg;
                phase_val  = 1'b0;
                emit_req   = !cur_pulse;
                drv_color  = color_val;
                drv_lit    = !cmd_mode_reg;
            end
            rgbsls_pkg::UOP_PREQ: begin
                if (cmd_led_reg == rgbsls_pkg::LED_GPS) begin
                    go_pulse = !cur_pulse && (gap_cnt_reg >= min_gap_reg);
                end else if (cmd_led_reg == rgbsls_pkg::LED_STEER) begin
                    go_pulse = 1'b1;
                end
                pulse_we  = go_pulse;
                pulse_val = 1'b1;
                age_we    = go_pulse;
                age_val   = '0;
                emit_req  = go_pulse;
                drv_pulse = 1'b1;
            end
            rgbsls_pkg::UOP_FLUSH: begin
                flush_req = hold_valid_reg;
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    // Output staging: a new beat pushes the held one out
    assign out_free = !m_valid_reg || m_ready;
    assign stall    = (emit_req || flush_req) && hold_valid_reg && !out_free;
    assign m_load   = !stall && (emit_req || flush_req) && hold_valid_reg;

    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        hold_valid_next = hold_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end
        if (!stall && emit_req) begin
            hold_valid_next = 1'b1;
        end else if (!stall && flush_req) begin
            hold_valid_next = 1'b0;
        end
    end

    // Step counter, scan index and shared counters
    always_comb begin
        pc_next            = pc_reg;
        idx_next           = idx_reg;
        calib_pending_next = calib_pending_reg;
        shared_phase_next  = shared_phase_reg;
        blink_cnt_next     = blink_cnt_reg;
        gap_cnt_next       = gap_cnt_reg;
        latch_cmd          = 1'b0;

        if (!stall) begin
            case (uw.cond)
                rgbsls_pkg::COND_NEXT: begin
                    pc_next = pc_reg + rgbsls_pkg::pc_t'(1);
                end
                rgbsls_pkg::COND_JUMP: begin
                    pc_next = uw.target;
                end
                rgbsls_pkg::COND_NO_TOGGLE: begin
                    pc_next = toggled ? pc_reg + rgbsls_pkg::pc_t'(1) : uw.target;
                end
                rgbsls_pkg::COND_SCAN: begin
                    if (idx_reg == LAST_LED) begin
                        idx_next = '0;
                        pc_next  = uw.target;
                    end else begin
                        idx_next = idx_reg + LED_W'(1);
                    end
                end
                rgbsls_pkg::COND_DISPATCH: begin
                    if (calib_pending_reg) begin
                        pc_next = rgbsls_pkg::PC_CAL;
                    end else if (s_valid) begin
                        latch_cmd = 1'b1;
                        idx_next  = LED_W'(s_led_index);
                        case (rgbsls_pkg::cmd_t'(s_command))
                            rgbsls_pkg::CMD_TICK: begin
                                pc_next = rgbsls_pkg::PC_TICK;
                            end
                            rgbsls_pkg::CMD_SET: begin
                                pc_next = (int'(s_led_index) < LED_COUNT)
                                          ? rgbsls_pkg::PC_SET : rgbsls_pkg::PC_FINISH;
                            end
                            rgbsls_pkg::CMD_PULSE: begin
                                pc_next = (int'(s_led_index) < LED_COUNT)
                                          ? rgbsls_pkg::PC_PREQ : rgbsls_pkg::PC_FINISH;
                            end
                            default: begin
                                pc_next = rgbsls_pkg::PC_FINISH;
                            end
                        endcase
                    end
                end
                default: begin
                    pc_next = rgbsls_pkg::PC_IDLE;
                end
            endcase

            if (uw.op == rgbsls_pkg::UOP_TICK) begin
                idx_next     = '0;
                gap_cnt_next = (gap_cnt_reg == rgbsls_pkg::CNT_MAX) ? gap_cnt_reg
                                                                    : gap_cnt_reg + 16'd1;
                if (toggled) begin
                    blink_cnt_next    = '0;
                    shared_phase_next = !shared_phase_reg;
                end else begin
                    blink_cnt_next = blink_inc;
                end
            end
            if (go_pulse && (cmd_led_reg == rgbsls_pkg::LED_GPS)) begin
                gap_cnt_next = '0;
            end
            if (uw.cal_done) begin
                calib_pending_next = 1'b0;
            end
        end

        // A brightness change restarts any calibration already under way
        if (bright_write) begin
            calib_pending_next = 1'b1;
            if (calib_pending_reg && (pc_reg != rgbsls_pkg::PC_IDLE)) begin
                pc_next = rgbsls_pkg::PC_CAL;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg            <= rgbsls_pkg::PC_IDLE;
            idx_reg           <= '0;
            calib_pending_reg <= 1'b1;
            shared_phase_reg  <= 1'b0;
            blink_cnt_reg     <= '0;
            gap_cnt_reg       <= '0;
            hold_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            pc_reg            <= pc_next;
            idx_reg           <= idx_next;
            calib_pending_reg <= calib_pending_next;
            shared_phase_reg  <= shared_phase_next;
            blink_cnt_reg     <= blink_cnt_next;
            gap_cnt_reg       <= gap_cnt_next;
            hold_valid_reg    <= hold_valid_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg      <= rgbsls_pkg::BRIGHT_RESET;
            half_period_reg <= rgbsls_pkg::BLINK_HALF_RESET;
            pulse_len_reg   <= rgbsls_pkg::PULSE_LEN_RESET;
            min_gap_reg     <= rgbsls_pkg::PULSE_GAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                rgbsls_pkg::REG_BRIGHTNESS: bright_reg      <= bright_clamped;
                rgbsls_pkg::REG_BLINK_HALF: half_period_reg <= cfg_data;
                rgbsls_pkg::REG_PULSE_LEN:  pulse_len_reg   <= cfg_data;
                rgbsls_pkg::REG_PULSE_GAP:  min_gap_reg     <= cfg_data;
                default:                    bright_reg      <= bright_reg;
            endcase
        end
    end

    // Per-LED state, written at the scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                color_reg[i]    <= (i < 2) ? rgbsls_pkg::COLOR_RED :
                                   (i == 2) ? rgbsls_pkg::COLOR_YELLOW :
                                   rgbsls_pkg::COLOR_OFF;
                blinks_reg[i]   <= 1'b0;
                phase_reg[i]    <= 1'b0;
                pulse_on_reg[i] <= 1'b0;
                age_reg[i]      <= '0;
            end
        end else if (!stall) begin
            if (color_we)  color_reg[idx_reg]    <= color_val;
            if (blinks_we) blinks_reg[idx_reg]   <= blinks_val;
            if (phase_we)  phase_reg[idx_reg]    <= phase_val;
            if (pulse_we)  pulse_on_reg[idx_reg] <= pulse_val;
            if (age_we)    age_reg[idx_reg]      <= age_val;
        end
    end

    // Datapath and payload registers
    always_ff @(posedge aclk) begin
        if (latch_cmd) begin
            cmd_led_reg   <= s_led_index;
            cmd_color_reg <= s_color_code;
            cmd_mode_reg  <= s_blink_mode;
        end
        if (uw.op == rgbsls_pkg::UOP_MUL) begin
            acc_reg <= ACC_W'(mul_a) * ACC_W'(mul_b);
        end
        if (uw.op == rgbsls_pkg::UOP_DIVM) begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(rgbsls_pkg::RECIP_100);
        end
        if (uw.op == rgbsls_pkg::UOP_DIVC) begin
            case (uw.dst)
                rgbsls_pkg::DST_FULL:  full_s_reg <= quot;
                rgbsls_pkg::DST_HALF:  half_s_reg <= quot;
                rgbsls_pkg::DST_RED_R: red_r_reg  <= quot;
                rgbsls_pkg::DST_YEL_R: yel_r_reg  <= quot;
                rgbsls_pkg::DST_YEL_G: yel_g_reg  <= quot;
                default:               full_s_reg <= full_s_reg;
            endcase
        end
        if (!stall && emit_req) begin
            hold_led_reg <= 2'(idx_reg);
            hold_r_reg   <= drv_r;
            hold_g_reg   <= drv_g;
            hold_b_reg   <= drv_b;
        end
        if (m_load) begin
            m_led_reg  <= hold_led_reg;
            m_r_reg    <= hold_r_reg;
            m_g_reg    <= hold_g_reg;
            m_b_reg    <= hold_b_reg;
            m_last_reg <= flush_req;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_led_number  = m_led_reg;
    assign m_red_duty    = m_r_reg;
    assign m_green_duty  = m_g_reg;
    assign m_blue_duty   = m_b_reg;
    assign m_last_update = m_last_reg;

endmodule
